>>> hdl/sag_pkg.sv
// Shared types, constants and the raised-sine shape table for the step gate.
`timescale 1ns / 1ps
package sag_pkg;

  localparam int MAX_STEPS   = 16;
  localparam int NUM_MARKERS = MAX_STEPS - 1;
  localparam int STEP_W      = $clog2(MAX_STEPS);
  localparam int CNT_W       = $clog2(MAX_STEPS + 1);
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int LVL_W       = 16;
  localparam int MK_W        = 17;

  localparam logic [16:0] FULL_LEVEL = 17'd32768;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [16:0] LEN_MIN    = 17'd655;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_LEVEL  = 3'd1,
    OP_MARKER = 3'd2,
    OP_PHASE  = 3'd3,
    OP_COUNT  = 3'd4
  } sag_op_e;

  typedef enum logic [2:0] {
    REG_INC   = 3'd0,
    REG_ATK   = 3'd1,
    REG_REL   = 3'd2,
    REG_BLEND = 3'd3,
    REG_DW    = 3'd4,
    REG_BYP   = 3'd5
  } sag_reg_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic [3:0]         index;
    logic [16:0]        value;
  } sag_in_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
    logic [3:0]         active_step;
  } sag_out_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } sag_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } sag_div_rsp_t;

  typedef logic [15:0] sine_tab_t [SINE_DEPTH];

  // 0.5*(1-cos(pi*k/D)) in Q1.15 for the first half, Taylor series in Q30.
  // Term n divides by (2n-1)*(2n): 2, 12, 30, 56, 90, 132, 182.
  function automatic logic [15:0] half_cos_shape(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          s;
    x    = (PI_Q30 * longint'(k)) / SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 64'd2;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd132;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd182;
    sum  = sum - longint'(term);
    s = ((longint'(1) << 30) - sum) / 2;
    if (s < 0) s = 0;
    s = (s + 16384) / 32768;
    return (s > 32768) ? 16'h8000 : s[15:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int k = 0; k <= SINE_DEPTH / 2; k++) t[k] = half_cos_shape(k);
    for (int k = SINE_DEPTH / 2 + 1; k < SINE_DEPTH; k++) begin
      t[k] = 16'h8000 - t[SINE_DEPTH - k];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

>>> hdl/sag_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sag_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sag_div.sv
// Radix-2 restoring divider, 32-bit dividend by 17-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module sag_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sag_pkg::sag_div_req_t req_i,
  output sag_pkg::sag_div_rsp_t rsp_o
);
  import sag_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [16:0] dvs_q;
  logic [16:0] rem_q;
  logic [17:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, dvd_q[31]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= fits ? 17'(rem_sh - {1'b0, dvs_q}) : rem_sh[16:0];
        dvd_q <= {dvd_q[30:0], fits};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

>>> hdl/step_sequenced_audio_gate_core.sv
// Top level of the stereo step gate: config port, sequencer, memories and datapath.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------
//   in       | in        | in_valid_i/in_ready_o | in_item_i  (sag_in_t)
//   out      | out       | out_valid_o/out_ready_i | out_item_o (sag_out_t)
//   config   | in        | psel/penable/pready   | paddr/pwdata/prdata
//
// Items are handled one at a time. A gated sample runs the step search
//   (S_SR_CHK and S_SR_DAT for each marker visited, for the marker RAM read),
//   the fraction divide and one divide for each attack or release ramp.
//   Bypassed samples skip the divides; stopped samples go straight to output.
//   Level, phase and ignored items are handled in the idle state.
// Marker writes that change a marker and step count changes re-spread the
//   auto markers, using the shared serial divider.
// Reset: a full re-spread pass fills the marker RAM; no item is taken
//   meanwhile. Level entries not yet written read as full level.
// Stalls: the output register frees the datapath; the sequencer only waits
//   at the end of a sample if the previous result has not been taken.
`timescale 1ns / 1ps
module step_sequenced_audio_gate_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sag_pkg::sag_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sag_pkg::sag_out_t out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import sag_pkg::*;

  typedef enum logic [5:0] {
    S_RS_LOOP, S_RS_ANC, S_RS_ANCD, S_RS_SUC, S_RS_SUCD, S_RS_J, S_RS_JW,
    S_IDLE, S_MK_RD, S_MK_CMP,
    S_SR_CHK, S_SR_DAT, S_FRAC, S_FRAC_W, S_TRK,
    S_LV_A, S_LV_P, S_LV_N, S_LV_D,
    S_ATK, S_ATK_W, S_REL, S_REL_W, S_RMP_TAB, S_RMP_MUL, S_RMP_ADD,
    S_GL, S_GR, S_MXL, S_MXL2, S_MXR, S_MXR2, S_OUT
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers (lengths and dry/wet clamped on write)
  // ---------------------------------------------------------------------
  logic [31:0] inc_q;
  logic [16:0] atk_q, rel_q, dw_q;
  logic        blend_q, byp_q;
  logic        cfg_we;
  sag_reg_e    cfg_idx;

  function automatic logic [16:0] clamp_len(input logic [16:0] v);
    if (v < LEN_MIN) return LEN_MIN;
    if (v > ONE_Q16) return ONE_Q16;
    return v;
  endfunction

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = sag_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q   <= '0;
      atk_q   <= 17'd13107;
      rel_q   <= 17'd13107;
      blend_q <= 1'b0;
      dw_q    <= ONE_Q16;
      byp_q   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_INC:   inc_q   <= pwdata;
        REG_ATK:   atk_q   <= clamp_len(pwdata[16:0]);
        REG_REL:   rel_q   <= clamp_len(pwdata[16:0]);
        REG_BLEND: blend_q <= pwdata[0];
        REG_DW:    dw_q    <= (pwdata[16:0] > ONE_Q16) ? ONE_Q16 : pwdata[16:0];
        REG_BYP:   byp_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INC:   prdata = inc_q;
      REG_ATK:   prdata = {15'd0, atk_q};
      REG_REL:   prdata = {15'd0, rel_q};
      REG_BLEND: prdata = {31'd0, blend_q};
      REG_DW:    prdata = {15'd0, dw_q};
      REG_BYP:   prdata = {31'd0, byp_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------
  state_e                  state_q;
  sag_in_t                 item_q;
  logic [31:0]             phase_q;
  logic [CNT_W-1:0]        count_q;
  logic [STEP_W-1:0]       cur_q, prev_q, fol_q, st_q, lv_addr_q;
  logic [NUM_MARKERS-1:0]  auto_q;
  logic [MAX_STEPS-1:0]    lvl_vld_q;
  logic [STEP_W-1:0]       rs_i_q, rs_start_q, rs_j_q;
  logic [16:0]             anc_q, suc_q, sp_q, np_q, mk_val_q, frac_q;
  logic [16:0]             act_q, prv_q, nxt_q, vol_q, base_q;
  logic signed [17:0]      diff_q;
  logic [15:0]             r_q, shp_q;
  logic signed [35:0]      prod_q;
  logic signed [23:0]      wl_q, wr_q;
  logic signed [42:0]      acc_q;
  sag_out_t                res_q;
  sag_out_t                out_q;
  logic                    out_valid_q, stopped_q, ramp_rel_q;
  logic                    out_load;

  // memories and divider
  logic                    mk_we, lvl_we;
  logic [STEP_W-1:0]       mk_waddr, mk_raddr, lvl_raddr;
  logic [MK_W-1:0]         mk_wdata, mk_rdata;
  logic [LVL_W-1:0]        lvl_rdata;
  sag_div_req_t            div_req;
  sag_div_rsp_t            div_rsp;

  sag_op_e                 in_op;
  logic                    in_acc;
  logic [16:0]             lvl_rd;
  logic [16:0]             mk_clamped;
  logic [CNT_W-1:0]        cnt_clamped;
  logic signed [17:0]      step_size;
  logic signed [33:0]      frac_num;
  logic [16:0]             rel_span;
  logic [CNT_W-1:0]        rs_i_w;

  assign in_op      = sag_op_e'(in_item_i.operation);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  // result register takes a new item when it is empty or being drained
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign lvl_rd = lvl_vld_q[lv_addr_q] ? {1'b0, lvl_rdata} : FULL_LEVEL;
  assign mk_clamped = (in_item_i.value > ONE_Q16) ? ONE_Q16 : in_item_i.value;
  assign cnt_clamped = (in_item_i.value == 17'd0) ? CNT_W'(1) :
                       (in_item_i.value > 17'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) :
                       in_item_i.value[CNT_W-1:0];
  assign step_size = $signed({1'b0, np_q}) - $signed({1'b0, sp_q});
  assign frac_num  = $signed({2'b00, phase_q}) - $signed({1'b0, sp_q, 16'd0});
  assign rel_span  = ONE_Q16 - frac_q;
  assign rs_i_w    = CNT_W'(rs_i_q);

  // signed divide by 2^sh, truncating toward zero
  function automatic logic signed [47:0] sdiv_p2(input logic signed [47:0] v,
                                                 input int unsigned sh);
    logic signed [47:0] mag;
    logic signed [47:0] q;
    mag = (v < 0) ? -v : v;
    q   = mag >>> sh;
    return (v < 0) ? -q : q;
  endfunction

  sag_ram #(.Width(MK_W), .Depth(NUM_MARKERS)) u_mk_ram (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .raddr_i (mk_raddr),
    .rdata_o (mk_rdata)
  );

  sag_ram #(.Width(LVL_W), .Depth(MAX_STEPS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (in_item_i.index),
    .wdata_i ((in_item_i.value > FULL_LEVEL) ? 16'h8000 : in_item_i.value[15:0]),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  sag_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign lvl_we = in_acc && (in_op == OP_LEVEL);

  // Memory ports and divider requests. The sequencer never reads a marker in
  // the cycle it writes one, and re-spread only reads fixed markers.
  always_comb begin
    mk_we     = 1'b0;
    mk_waddr  = rs_j_q;
    mk_wdata  = anc_q;
    mk_raddr  = st_q;
    lvl_raddr = cur_q;
    div_req   = '0;
    case (state_q)
      S_RS_ANC: mk_raddr = rs_start_q - STEP_W'(1);
      S_RS_SUC: mk_raddr = rs_i_q + STEP_W'(1);
      S_RS_J: begin
        if (rs_j_q <= rs_i_q) begin
          if (suc_q <= anc_q) begin
            mk_we = 1'b1;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'(suc_q - anc_q) *
                               32'(CNT_W'(rs_j_q) + CNT_W'(1) - CNT_W'(rs_start_q));
            div_req.divisor  = 17'(rs_i_w + CNT_W'(2) - CNT_W'(rs_start_q));
          end
        end
      end
      S_RS_JW: begin
        mk_we    = div_rsp.done;
        mk_wdata = anc_q + div_rsp.quotient[16:0];
      end
      S_MK_RD: mk_raddr = item_q.index;
      S_MK_CMP: begin
        mk_we    = (mk_rdata != mk_val_q);
        mk_waddr = item_q.index;
        mk_wdata = mk_val_q;
      end
      S_FRAC: begin
        if (step_size > 0) begin
          div_req.start    = 1'b1;
          div_req.dividend = (frac_num < 0) ? 32'd0 : frac_num[31:0];
          div_req.divisor  = step_size[16:0];
        end
      end
      S_LV_A: lvl_raddr = cur_q;
      S_LV_P: lvl_raddr = prev_q;
      S_LV_N: lvl_raddr = fol_q;
      S_ATK: begin
        if (frac_q < atk_q && prv_q < act_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = {frac_q[15:0], 16'd0};
          div_req.divisor  = atk_q;
        end
      end
      S_REL: begin
        if ((18'(frac_q) + 18'(rel_q)) > 18'(ONE_Q16) && nxt_q < act_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = {rel_span[15:0], 16'd0};
          div_req.divisor  = rel_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RS_LOOP;
      item_q      <= '0;
      phase_q     <= '0;
      count_q     <= CNT_W'(MAX_STEPS);
      cur_q       <= '0;
      prev_q      <= '0;
      fol_q       <= STEP_W'(1);
      st_q        <= '0;
      lv_addr_q   <= '0;
      auto_q      <= '1;
      lvl_vld_q   <= '0;
      rs_i_q      <= '0;
      rs_start_q  <= '0;
      rs_j_q      <= '0;
      anc_q       <= '0;
      suc_q       <= '0;
      sp_q        <= '0;
      np_q        <= '0;
      mk_val_q    <= '0;
      frac_q      <= '0;
      act_q       <= '0;
      prv_q       <= '0;
      nxt_q       <= '0;
      vol_q       <= '0;
      base_q      <= '0;
      diff_q      <= '0;
      r_q         <= '0;
      shp_q       <= '0;
      prod_q      <= '0;
      wl_q        <= '0;
      wr_q        <= '0;
      acc_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      stopped_q   <= 1'b0;
      ramp_rel_q  <= 1'b0;
    end else begin
      lv_addr_q <= lvl_raddr;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // ---- re-spread of auto markers ----
        S_RS_LOOP: begin
          if (rs_i_w >= count_q - CNT_W'(1)) begin
            state_q <= S_IDLE;
          end else if (!auto_q[rs_i_q]) begin
            rs_start_q <= rs_i_q + STEP_W'(1);
            rs_i_q     <= rs_i_q + STEP_W'(1);
          end else if ((rs_i_w + CNT_W'(2) == count_q) ||
                       !auto_q[rs_i_q + STEP_W'(1)]) begin
            state_q <= S_RS_ANC;
          end else begin
            rs_i_q <= rs_i_q + STEP_W'(1);
          end
        end
        S_RS_ANC: begin
          if (rs_start_q == '0) begin
            anc_q   <= '0;
            state_q <= S_RS_SUC;
          end else begin
            state_q <= S_RS_ANCD;
          end
        end
        S_RS_ANCD: begin
          anc_q   <= mk_rdata;
          state_q <= S_RS_SUC;
        end
        S_RS_SUC: begin
          rs_j_q <= rs_start_q;
          if (rs_i_w + CNT_W'(2) == count_q) begin
            suc_q   <= ONE_Q16;
            state_q <= S_RS_J;
          end else begin
            state_q <= S_RS_SUCD;
          end
        end
        S_RS_SUCD: begin
          suc_q   <= mk_rdata;
          state_q <= S_RS_J;
        end
        S_RS_J: begin
          if (rs_j_q > rs_i_q) begin
            rs_i_q  <= rs_i_q + STEP_W'(1);
            state_q <= S_RS_LOOP;
          end else if (suc_q <= anc_q) begin
            rs_j_q <= rs_j_q + STEP_W'(1);
          end else begin
            state_q <= S_RS_JW;
          end
        end
        S_RS_JW: begin
          if (div_rsp.done) begin
            rs_j_q  <= rs_j_q + STEP_W'(1);
            state_q <= S_RS_J;
          end
        end

        // ---- item decode ----
        S_IDLE: begin
          if (in_acc) begin
            item_q <= in_item_i;
            case (in_op)
              OP_SAMPLE: begin
                st_q <= '0;
                sp_q <= '0;
                if (inc_q == 32'd0) begin
                  stopped_q <= 1'b1;
                  state_q   <= S_OUT;
                end else begin
                  stopped_q <= 1'b0;
                  state_q   <= S_SR_CHK;
                end
              end
              OP_LEVEL: lvl_vld_q[in_item_i.index] <= 1'b1;
              OP_MARKER: begin
                if (5'(in_item_i.index) < 5'(NUM_MARKERS)) begin
                  mk_val_q <= mk_clamped;
                  if (mk_clamped == 17'd0) begin
                    if (!auto_q[in_item_i.index]) begin
                      auto_q[in_item_i.index] <= 1'b1;
                      rs_i_q     <= '0;
                      rs_start_q <= '0;
                      state_q    <= S_RS_LOOP;
                    end
                  end else begin
                    state_q <= S_MK_RD;
                  end
                end
              end
              OP_PHASE: phase_q <= {in_item_i.value[15:0], 16'd0};
              OP_COUNT: begin
                if (cnt_clamped != count_q) begin
                  count_q    <= cnt_clamped;
                  rs_i_q     <= '0;
                  rs_start_q <= '0;
                  state_q    <= S_RS_LOOP;
                end
              end
              default: ;
            endcase
          end
        end
        S_MK_RD: state_q <= S_MK_CMP;
        S_MK_CMP: begin
          if (mk_rdata != mk_val_q) begin
            auto_q[item_q.index] <= 1'b0;
            rs_i_q     <= '0;
            rs_start_q <= '0;
            state_q    <= S_RS_LOOP;
          end else begin
            state_q <= S_IDLE;
          end
        end

        // ---- step search: first marker at or above the phase ----
        S_SR_CHK: begin
          if (CNT_W'(st_q) + CNT_W'(1) >= count_q) begin
            np_q    <= ONE_Q16;
            state_q <= byp_q ? S_MXL : S_FRAC;
          end else begin
            state_q <= S_SR_DAT;
          end
          wl_q <= item_q.left_in;
          wr_q <= item_q.right_in;
        end
        S_SR_DAT: begin
          if ({mk_rdata, 16'd0} < {1'b0, phase_q}) begin
            sp_q    <= mk_rdata;
            st_q    <= st_q + STEP_W'(1);
            state_q <= S_SR_CHK;
          end else begin
            np_q    <= mk_rdata;
            state_q <= byp_q ? S_MXL : S_FRAC;
          end
        end
        S_FRAC: begin
          frac_q  <= '0;
          state_q <= (step_size > 0) ? S_FRAC_W : S_TRK;
        end
        S_FRAC_W: begin
          if (div_rsp.done) begin
            frac_q  <= (div_rsp.quotient > 32'(ONE_Q16)) ? ONE_Q16 :
                       div_rsp.quotient[16:0];
            state_q <= S_TRK;
          end
        end
        S_TRK: begin
          if (cur_q != st_q) begin
            prev_q <= cur_q;
            cur_q  <= st_q;
            fol_q  <= (CNT_W'(st_q) + CNT_W'(1) < count_q) ? st_q + STEP_W'(1) : '0;
          end
          state_q <= S_LV_A;
        end

        // ---- level fetch: active, previous, following ----
        S_LV_A: state_q <= S_LV_P;
        S_LV_P: begin
          act_q   <= lvl_rd;
          state_q <= S_LV_N;
        end
        S_LV_N: begin
          prv_q   <= lvl_rd;
          state_q <= S_LV_D;
        end
        S_LV_D: begin
          nxt_q   <= lvl_rd;
          state_q <= S_ATK;
        end

        // ---- attack / release ramps ----
        S_ATK: begin
          vol_q <= act_q;
          if (frac_q < atk_q && prv_q < act_q) begin
            base_q     <= prv_q;
            diff_q     <= $signed({1'b0, act_q}) - $signed({1'b0, prv_q});
            ramp_rel_q <= 1'b0;
            state_q    <= S_ATK_W;
          end else begin
            state_q <= S_REL;
          end
        end
        S_ATK_W, S_REL_W: begin
          if (div_rsp.done) begin
            r_q     <= div_rsp.quotient[15:0];
            state_q <= S_RMP_TAB;
          end
        end
        S_REL: begin
          if ((18'(frac_q) + 18'(rel_q)) > 18'(ONE_Q16) && nxt_q < act_q) begin
            base_q     <= nxt_q;
            diff_q     <= $signed({1'b0, vol_q}) - $signed({1'b0, nxt_q});
            ramp_rel_q <= 1'b1;
            state_q    <= S_REL_W;
          end else begin
            state_q <= S_GL;
          end
        end
        S_RMP_TAB: begin
          shp_q   <= blend_q ? SINE_TAB[r_q[15 -: SINE_IDX_W]] : r_q;
          state_q <= S_RMP_MUL;
        end
        S_RMP_MUL: begin
          prod_q  <= diff_q * $signed({1'b0, shp_q});
          state_q <= S_RMP_ADD;
        end
        S_RMP_ADD: begin
          vol_q   <= 17'($signed({31'd0, base_q}) +
                         sdiv_p2(48'(prod_q), blend_q ? 15 : 16));
          state_q <= ramp_rel_q ? S_GL : S_REL;
        end

        // ---- gain and dry/wet mix ----
        S_GL: begin
          wl_q    <= 24'(sdiv_p2(48'(item_q.left_in * $signed({1'b0, vol_q})), 15));
          state_q <= S_GR;
        end
        S_GR: begin
          wr_q    <= 24'(sdiv_p2(48'(item_q.right_in * $signed({1'b0, vol_q})), 15));
          state_q <= S_MXL;
        end
        S_MXL: begin
          acc_q   <= item_q.left_in * $signed({1'b0, ONE_Q16 - dw_q});
          state_q <= S_MXL2;
        end
        S_MXL2: begin
          res_q.left_out <= 24'(sdiv_p2(48'(acc_q + wl_q * $signed({1'b0, dw_q})), 16));
          state_q <= S_MXR;
        end
        S_MXR: begin
          acc_q   <= item_q.right_in * $signed({1'b0, ONE_Q16 - dw_q});
          state_q <= S_MXR2;
        end
        S_MXR2: begin
          res_q.right_out <= 24'(sdiv_p2(48'(acc_q + wr_q * $signed({1'b0, dw_q})), 16));
          res_q.active_step <= 4'(st_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (stopped_q) begin
              out_q.left_out    <= '0;
              out_q.right_out   <= '0;
              out_q.active_step <= 4'(cur_q);
            end else begin
              out_q   <= res_q;
              phase_q <= phase_q + inc_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_trk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRK) |-> (frac_q <= ONE_Q16) && (CNT_W'(st_q) < count_q))
    else $error("fraction or step out of range at tracking");

  a_vol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GL) |-> (vol_q <= FULL_LEVEL))
    else $error("gain above full level");

endmodule
